// ----- hw/rtl/fm_quadrature_discriminator_assert.svh -----
// Assertion macros for the FM quadrature discriminator.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef FM_QUADRATURE_DISCRIMINATOR_ASSERT_SVH
`define FM_QUADRATURE_DISCRIMINATOR_ASSERT_SVH

// same-cycle implication
`define FMQD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FMQD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/fmqd_pkg.sv -----
// Package for the FM quadrature discriminator: item types, widths, angle table.
// No dependencies.
`default_nettype none

package fmqd_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int AUDIO_BITS    = 16;
    localparam int TABLE_LEN     = 24;
    localparam int N_STAGES      = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

    localparam int RAW_W       = 8;
    localparam int SMP_W       = 9;
    localparam int RE_W        = 19;
    localparam int PRESCALE_SH = 24;
    localparam int XY_W        = 42;
    localparam int ANG_FRAC    = 30;
    localparam int Z_W         = 33;
    localparam int P_SH        = ANG_FRAC - (AUDIO_BITS - 1);
    localparam int P_W         = AUDIO_BITS + 2;
    localparam int G_W         = P_W + 1;
    localparam int AUDIO_W     = 16;
    localparam int GP_W        = G_W + AUDIO_W - 1;
    localparam int SHIFT_W     = 5;

    localparam int ATAN_TAB [TABLE_LEN] = '{
        268435456, 158466703, 83729454, 42502378, 21333666, 10677233,
        5339919, 2670123, 1335082, 667543, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608,
        1304, 652, 326, 163, 81, 41
    };

    typedef struct packed {
        logic [RAW_W-1:0] i_raw;
        logic [RAW_W-1:0] q_raw;
        logic             first_of_block;
    } t_in_item;

    typedef struct packed {
        logic signed [AUDIO_W-1:0] audio_sample;
        logic                      was_muted;
    } t_out_item;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   first;
        logic                   zero;
    } t_cordic;

endpackage

`default_nettype wire

// ----- hw/rtl/fmqd_cordic_cell.sv -----
// One vectoring CORDIC step: rotates toward the x axis and accumulates the angle.
// Depends on fmqd_pkg.
`default_nettype none

module fmqd_cordic_cell
    import fmqd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire t_cordic             i_data,
    input  wire logic [SHIFT_W-1:0]  i_shift,
    input  wire logic signed [Z_W-1:0] i_atan,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output t_cordic                  o_data
);

    logic    r_valid;
    t_cordic r_data;
    t_cordic n_data;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        xs     = i_data.x >>> i_shift;
        ys     = i_data.y >>> i_shift;
        n_data = i_data;
        if (!i_data.y[XY_W-1]) begin
            n_data.x = i_data.x + ys;
            n_data.y = i_data.y - xs;
            n_data.z = i_data.z + i_atan;
        end else begin
            n_data.x = i_data.x - ys;
            n_data.y = i_data.y + xs;
            n_data.z = i_data.z - i_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/fmqd_front.sv -----
// Front end: offset removal, conjugate product with the previous sample,
// prescale and half-plane fold ahead of the CORDIC chain. Depends on fmqd_pkg.
`default_nettype none

module fmqd_front
    import fmqd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_data,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_cordic       o_data
);

    logic signed [SMP_W-1:0] r_last_i;
    logic signed [SMP_W-1:0] r_last_q;
    logic signed [SMP_W-1:0] ci;
    logic signed [SMP_W-1:0] cq;

    logic                   r_a_valid;
    logic signed [RE_W-1:0] r_re;
    logic signed [RE_W-1:0] r_im;
    logic                   r_a_first;
    logic signed [RE_W-1:0] n_re;
    logic signed [RE_W-1:0] n_im;

    logic    r_b_valid;
    t_cordic r_b_data;
    t_cordic n_b_data;
    logic    a_ready;
    logic    b_ready;
    logic signed [XY_W-1:0] xe;
    logic signed [XY_W-1:0] ye;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;
    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;

    always_comb begin
        ci   = signed'({1'b0, i_data.i_raw}) - signed'(SMP_W'(127));
        cq   = signed'({1'b0, i_data.q_raw}) - signed'(SMP_W'(127));
        n_re = RE_W'(ci) * RE_W'(r_last_i) + RE_W'(cq) * RE_W'(r_last_q);
        n_im = RE_W'(cq) * RE_W'(r_last_i) - RE_W'(ci) * RE_W'(r_last_q);
    end

    always_comb begin
        xe             = XY_W'(r_re) <<< PRESCALE_SH;
        ye             = XY_W'(r_im) <<< PRESCALE_SH;
        n_b_data.first = r_a_first;
        n_b_data.zero  = (r_re == '0) && (r_im == '0);
        n_b_data.x     = xe;
        n_b_data.y     = ye;
        n_b_data.z     = '0;
        if (xe[XY_W-1]) begin
            n_b_data.x = -xe;
            n_b_data.y = -ye;
            n_b_data.z = r_im[RE_W-1] ? -(Z_W'(1) <<< ANG_FRAC) : (Z_W'(1) <<< ANG_FRAC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_i  <= '0;
            r_last_q  <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (i_valid && a_ready) begin
                r_last_i <= ci;
                r_last_q <= cq;
            end
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && a_ready) begin
            r_re      <= n_re;
            r_im      <= n_im;
            r_a_first <= i_data.first_of_block;
        end
        if (r_a_valid && b_ready) begin
            r_b_data <= n_b_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/fmqd_back.sv -----
// Back end: angle rounding, glitch mute, gain, saturation and Q1.15 scaling.
// Depends on fmqd_pkg.
`default_nettype none

module fmqd_back
    import fmqd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_cordic i_data,
    input  wire logic    i_narrow,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_out_item    o_data
);

    logic signed [Z_W-1:0] zr;
    logic signed [P_W-1:0] p;
    logic [P_W-1:0]        mag;
    logic [G_W-1:0]        n_g;
    logic                  n_sat;
    logic                  n_muted;

    logic           r_c_valid;
    logic [G_W-1:0] r_g;
    logic           r_neg;
    logic           r_muted;
    logic           r_sat;
    logic           r_narrow;

    logic             r_d_valid;
    t_out_item        r_out;
    t_out_item        n_out;
    logic [GP_W-1:0]  prod;
    logic [GP_W-1:0]  scaled;
    logic [AUDIO_W-1:0] a;
    logic             c_ready;
    logic             d_ready;

    assign d_ready = !r_d_valid || i_ready;
    assign c_ready = !r_c_valid || d_ready;
    assign o_ready = c_ready;
    assign o_valid = r_d_valid;
    assign o_data  = r_out;

    always_comb begin
        zr      = i_data.z + (Z_W'(1) <<< (P_SH - 1));
        p       = P_W'(zr >>> P_SH);
        mag     = p[P_W-1] ? P_W'(-p) : P_W'(p);
        n_g     = (G_W'(mag) << 1) + G_W'(mag);
        n_sat   = i_narrow ? (n_g >= (G_W'(1) << (AUDIO_BITS - 1)))
                           : (n_g >= (G_W'(1) << AUDIO_BITS));
        n_muted = i_data.zero ||
                  (i_data.first && (mag > (P_W'(1) << (AUDIO_BITS - 2))));
    end

    always_comb begin
        prod   = (GP_W'(r_g) << (AUDIO_W - 1)) - GP_W'(r_g);
        scaled = r_narrow ? (prod >> (AUDIO_BITS - 1)) : (prod >> AUDIO_BITS);
        a      = r_sat ? {1'b0, {(AUDIO_W - 1){1'b1}}} : {1'b0, scaled[AUDIO_W-2:0]};
        n_out.was_muted    = r_muted;
        n_out.audio_sample = r_muted ? '0 : (r_neg ? -signed'(a) : signed'(a));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (c_ready) begin
                r_c_valid <= i_valid;
            end
            if (d_ready) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && c_ready) begin
            r_g      <= n_g;
            r_neg    <= p[P_W-1];
            r_muted  <= n_muted;
            r_sat    <= n_sat;
            r_narrow <= i_narrow;
        end
        if (r_c_valid && d_ready) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/fm_quadrature_discriminator.sv -----
// Top level of the FM quadrature discriminator: front end, CORDIC cell row, back end.
// Depends on fmqd_pkg, fmqd_front, fmqd_cordic_cell, fmqd_back and the assert header.
//
// Usage:
//   Input channel i_valid/o_ready carries one I/Q byte pair per item (i_data);
//   output channel o_valid/i_ready carries one Q1.15 audio item (o_data).
//   i_cfg_we/i_cfg_wdata write narrow_mode (gain 3 when set, 1.5 when clear);
//   write it only while no item is in flight.
//   Pipeline: an item passes N_STAGES + 4 register stages on its way to o_data.
//   Throughput: one item per cycle while i_ready is high; every stage has its
//   own valid/ready, so empty stages are filled while a result waits at the output.
//   The vectoring CORDIC row, one cell per iteration, sets the latency.
//   Reset (synchronous, active low) empties the pipeline, clears the stored
//   previous sample (so the first item after reset is muted) and clears
//   narrow_mode.
//   When the receiver stalls, results back up stage by stage; o_ready drops
//   once every stage holds an item.
`default_nettype none

`include "fm_quadrature_discriminator_assert.svh"

module fm_quadrature_discriminator
    import fmqd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_wdata,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_data
);

    logic r_narrow;

    logic    link_valid [N_STAGES+1];
    logic    link_ready [N_STAGES+1];
    t_cordic link_data  [N_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_narrow <= 1'b0;
        end else if (i_cfg_we) begin
            r_narrow <= i_cfg_wdata;
        end
    end

    fmqd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (link_valid[0]),
        .i_ready (link_ready[0]),
        .o_data  (link_data[0])
    );

    for (genvar k = 0; k < N_STAGES; k++) begin : g_cell
        fmqd_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (link_valid[k]),
            .o_ready (link_ready[k]),
            .i_data  (link_data[k]),
            .i_shift (SHIFT_W'(k)),
            .i_atan  (Z_W'(ATAN_TAB[k])),
            .o_valid (link_valid[k+1]),
            .i_ready (link_ready[k+1]),
            .o_data  (link_data[k+1])
        );
    end

    fmqd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (link_valid[N_STAGES]),
        .o_ready  (link_ready[N_STAGES]),
        .i_data   (link_data[N_STAGES]),
        .i_narrow (r_narrow),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data)
    );

    `FMQD_ASSERT_NOW(a_muted_is_zero, o_valid && o_data.was_muted, o_data.audio_sample == '0, "muted audio")
    `FMQD_ASSERT_NOW(a_no_neg_full, o_valid, o_data.audio_sample >= -32767, "audio below -32767")
    `FMQD_ASSERT_NEXT(a_accept_fills_front, i_valid && o_ready, u_front.r_a_valid, "item lost at front")

endmodule

`default_nettype wire
